// ===== sv/sos_pkg.sv =====
// shared types and constants of the shell operator spacer
// depends on nothing; every other file imports it
package sos_pkg;

  localparam int ByteW     = 8;
  localparam int MaxRes    = 6;
  localparam int CntW      = 3;
  localparam int FifoDepth = 2;   // power of two
  localparam int FifoAw    = $clog2(FifoDepth);

  localparam logic [ByteW-1:0] CH_LT  = 8'h3C;
  localparam logic [ByteW-1:0] CH_GT  = 8'h3E;
  localparam logic [ByteW-1:0] CH_BAR = 8'h7C;
  localparam logic [ByteW-1:0] CH_AMP = 8'h26;
  localparam logic [ByteW-1:0] CH_DQ  = 8'h22;
  localparam logic [ByteW-1:0] CH_SQ  = 8'h27;
  localparam logic [ByteW-1:0] CH_SP  = 8'h20;
  localparam logic [ByteW-1:0] CH_NUL = 8'h00;

  // one classified input beat: the bytes it causes, in order
  typedef struct packed {
    logic [MaxRes-1:0][ByteW-1:0] bytes;
    logic [CntW-1:0]              count;
    logic                         eol;
    logic                         err;
  } sos_rec_t;

  function automatic logic is_op(input logic [ByteW-1:0] c);
    return (c == CH_LT) || (c == CH_GT) || (c == CH_BAR) || (c == CH_AMP);
  endfunction

endpackage

// ===== sv/sos_if.sv =====
// valid/ready channel interfaces for the input and result beats
// depends on sos_pkg
interface sos_in_if;
  import sos_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;
  logic             line_end;
  modport source (output valid, output in_byte, output line_end, input ready);
  modport sink   (input valid, input in_byte, input line_end, output ready);
endinterface

interface sos_out_if;
  import sos_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic             run_last;
  logic             line_done;
  logic             line_error;
  modport source (output valid, output out_byte, output run_last, output line_done,
                  output line_error, input ready);
  modport sink   (input valid, input out_byte, input run_last, input line_done,
                  input line_error, output ready);
endinterface

// ===== sv/sos_front.sv =====
// front end: quote tracking, operator lookahead and error detection
// depends on sos_pkg and sos_if; pushes one record per productive beat
module sos_front (
  input  logic              clk,
  input  logic              rst_n,
  sos_in_if.sink            in_chan,
  input  logic              q_full,
  output logic              push,
  output sos_pkg::sos_rec_t push_rec
);
  import sos_pkg::*;

  typedef enum logic [1:0] {
    QUOTE_NONE   = 2'd0,
    QUOTE_DOUBLE = 2'd1,
    QUOTE_SINGLE = 2'd2
  } quote_t;

  quote_t           quote_r, quote_nxt;
  logic [ByteW-1:0] held_r, held_nxt;
  logic             disc_r, disc_nxt;
  sos_rec_t         rec;
  logic             rec_vld;
  logic             accept;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && !q_full;
  assign push          = accept && rec_vld;
  assign push_rec      = rec;

  // classify the beat against the held operator and quote mode
  always_comb begin
    logic [ByteW-1:0]       c, h;
    logic                   eol, hit, dbl, pair, flush;
    logic [2:0][ByteW-1:0]  tail;
    logic [CntW-1:0]        tail_n;
    c         = in_chan.in_byte;
    eol       = in_chan.line_end;
    h         = held_r;
    rec       = '0;
    rec_vld   = 1'b0;
    quote_nxt = quote_r;
    held_nxt  = held_r;
    disc_nxt  = disc_r;
    tail      = '0;
    tail_n    = '0;
    hit   = !disc_r && (h != CH_NUL);
    dbl   = hit && (((h == CH_AMP) && (c == CH_AMP)) || ((h == CH_BAR) && (c == CH_BAR)));
    pair  = hit && !dbl &&
            (((h == CH_GT) && (c == CH_GT)) || ((h == CH_LT) && (c == CH_LT)));
    flush = hit && !dbl && !pair;
    if (hit) held_nxt = CH_NUL;

    if (disc_r || dbl) begin
      // dropping the rest of the line; one error beat at its end
      disc_nxt = 1'b1;
      held_nxt = CH_NUL;
      if (eol) begin
        rec.count = CntW'(1);
        rec.eol   = 1'b1;
        rec.err   = 1'b1;
        rec_vld   = 1'b1;
        quote_nxt = QUOTE_NONE;
        disc_nxt  = 1'b0;
      end
    end else begin
      // handling of the new byte itself
      if (!pair) begin
        if (c == CH_DQ) begin
          if (quote_r == QUOTE_NONE) quote_nxt = QUOTE_DOUBLE;
          else if (quote_r == QUOTE_DOUBLE) quote_nxt = QUOTE_NONE;
          tail[0] = c;
          tail_n  = CntW'(1);
        end else if (c == CH_SQ) begin
          if (quote_r == QUOTE_NONE) quote_nxt = QUOTE_SINGLE;
          else if (quote_r == QUOTE_SINGLE) quote_nxt = QUOTE_NONE;
          tail[0] = c;
          tail_n  = CntW'(1);
        end else if ((quote_r == QUOTE_NONE) && is_op(c)) begin
          if (eol) begin
            tail   = {CH_SP, c, CH_SP};
            tail_n = CntW'(3);
          end else begin
            held_nxt = c;
          end
        end else begin
          tail[0] = c;
          tail_n  = CntW'(1);
        end
      end
      // build the record: a pair, the flushed operator ahead of the tail, or the tail alone
      if (pair) begin
        rec.bytes[0] = CH_SP;
        rec.bytes[1] = h;
        rec.bytes[2] = c;
        rec.bytes[3] = CH_SP;
        rec.count    = CntW'(4);
      end else if (flush) begin
        rec.bytes[0] = CH_SP;
        rec.bytes[1] = h;
        rec.bytes[2] = CH_SP;
        rec.bytes[3] = tail[0];
        rec.bytes[4] = tail[1];
        rec.bytes[5] = tail[2];
        rec.count    = CntW'(3) + tail_n;
      end else begin
        rec.bytes[0] = tail[0];
        rec.bytes[1] = tail[1];
        rec.bytes[2] = tail[2];
        rec.count    = tail_n;
      end
      rec.eol = eol;
      rec_vld = (rec.count != '0);
      if (eol) begin
        quote_nxt = QUOTE_NONE;
        held_nxt  = CH_NUL;
        disc_nxt  = 1'b0;
      end
    end
  end

  // line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quote_r <= QUOTE_NONE;
      held_r  <= CH_NUL;
      disc_r  <= 1'b0;
    end else if (accept) begin
      quote_r <= quote_nxt;
      held_r  <= held_nxt;
      disc_r  <= disc_nxt;
    end
  end

endmodule

// ===== sv/sos_fifo.sv =====
// short record queue between the front and back ends
// depends on sos_pkg
module sos_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sos_pkg::sos_rec_t push_rec,
  output logic              full,
  input  logic              pop,
  output logic              nonempty,
  output sos_pkg::sos_rec_t head
);
  import sos_pkg::*;

  sos_rec_t          mem_r [FifoDepth];
  logic [FifoAw-1:0] wr_ptr_r, rd_ptr_r;
  logic [FifoAw:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == (FifoAw+1)'(FifoDepth));
  assign nonempty = (cnt_r != '0);
  assign head     = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + (FifoAw+1)'(1);
    else if (pop && !push) cnt_nxt = cnt_r - (FifoAw+1)'(1);
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + FifoAw'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + FifoAw'(1);
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_rec;
  end

endmodule

// ===== sv/sos_back.sv =====
// back end: plays out each record one byte per beat
// depends on sos_pkg and sos_if
module sos_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_nonempty,
  input  sos_pkg::sos_rec_t q_head,
  output logic              pop,
  sos_out_if.source         out_chan
);
  import sos_pkg::*;

  sos_rec_t        cur_r;
  logic [CntW-1:0] idx_r;
  logic            busy_r;
  logic            last;
  logic            take;

  assign last = (idx_r == (cur_r.count - CntW'(1)));
  assign take = busy_r && out_chan.ready;
  assign pop  = q_nonempty && (!busy_r || (take && last));

  assign out_chan.valid      = busy_r;
  assign out_chan.out_byte   = cur_r.bytes[idx_r];
  assign out_chan.run_last   = last;
  assign out_chan.line_done  = last && cur_r.eol;
  assign out_chan.line_error = cur_r.err;

  // control: busy flag and byte index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (pop) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (take) begin
      if (last) busy_r <= 1'b0;
      else idx_r <= idx_r + CntW'(1);
    end
  end

  // current record
  always_ff @(posedge clk) begin
    if (pop) cur_r <= q_head;
  end

endmodule

// ===== sv/shell_operator_spacer_top.sv =====
// top level of the shell operator spacer: front end, record queue, back end
// depends on sos_pkg, sos_if, sos_front, sos_fifo, sos_back
//
//   channel   dir  beat fields
//   in_chan   in   in_byte[7:0], line_end
//   out_chan  out  out_byte[7:0], run_last, line_done, line_error
//
// one input beat per cycle while the two-record queue has room; each beat
// makes zero to six result beats, played out one per cycle by the back end
// while out_chan is ready. An input beat is registered into the queue and then
// into the back end's current record before its first result beat is shown.
// rst_n is synchronous, active low, and clears line state and queue.
// out_chan stalls only the back end until the queue fills.
module shell_operator_spacer_top (
  input  logic       clk,
  input  logic       rst_n,
  sos_in_if.sink     in_chan,
  sos_out_if.source  out_chan
);
  import sos_pkg::*;

  logic     push, pop, q_full, q_nonempty;
  sos_rec_t push_rec, q_head;

  sos_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .q_full   (q_full),
    .push     (push),
    .push_rec (push_rec)
  );

  sos_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (pop),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  sos_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .pop        (pop),
    .out_chan   (out_chan)
  );

endmodule

// ===== tb/shell_operator_spacer_top_tb.sv =====
// self-checking testbench for shell_operator_spacer_top: a directed table, then random lines
// depends on sos_pkg, sos_if and the rtl under test; expected beats come from a local predictor or the directed table
module shell_operator_spacer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sos_pkg::*;

  localparam int RandomChars = 280;
  localparam int FromModel   = -1;   // row expectation taken from the predictor

  typedef enum logic [1:0] {
    QUOTE_NONE   = 2'd0,
    QUOTE_DOUBLE = 2'd1,
    QUOTE_SINGLE = 2'd2
  } quote_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             run_last;
    logic             line_done;
    logic             line_error;
  } spaced_beat_t;

  // directed row: n_typed is the number of result beats typed in (0 or 1), or FromModel
  typedef struct {
    logic [ByteW-1:0] ch;
    logic             eol;
    int               n_typed;
    logic [ByteW-1:0] typed_byte;
    logic             typed_done;
    logic             typed_err;
  } plan_row_t;

  logic clk;
  logic rst_n;
  logic steady;   // no idling on either side while set
  int   mismatches;

  sos_in_if  in_chan ();
  sos_out_if out_chan ();

  shell_operator_spacer_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // predictor state
  quote_t           quote_now;
  logic [ByteW-1:0] held_op;
  logic             dropping_line;
  spaced_beat_t     step_beats [$];
  spaced_beat_t     spaced_q [$];

  plan_row_t plan [25];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one character through the spacer; leaves the beats it causes in step_beats
  function automatic void space_step(input logic [ByteW-1:0] c, input logic eol);
    logic [ByteW-1:0] h;
    logic             handled;
    logic [ByteW-1:0] seq [$];
    handled = 1'b0;
    step_beats.delete();
    // settle the held operator against its successor
    if (!dropping_line && held_op != CH_NUL) begin
      h = held_op;
      held_op = CH_NUL;
      if ((h == CH_AMP || h == CH_BAR) && c == h) begin
        dropping_line = 1'b1;
        handled = 1'b1;
      end else if ((h == CH_GT || h == CH_LT) && c == h) begin
        seq.push_back(CH_SP);
        seq.push_back(h);
        seq.push_back(c);
        seq.push_back(CH_SP);
        handled = 1'b1;
      end else begin
        seq.push_back(CH_SP);
        seq.push_back(h);
        seq.push_back(CH_SP);
      end
    end
    if (dropping_line) begin
      // rest of the line is swallowed, one error beat closes it
      if (eol) begin
        step_beats.push_back('{CH_NUL, 1'b1, 1'b1, 1'b1});
        quote_now = QUOTE_NONE;
        held_op = CH_NUL;
        dropping_line = 1'b0;
      end
    end else begin
      if (!handled) begin
        if (c == CH_DQ) begin
          if (quote_now == QUOTE_NONE) quote_now = QUOTE_DOUBLE;
          else if (quote_now == QUOTE_DOUBLE) quote_now = QUOTE_NONE;
          seq.push_back(c);
        end else if (c == CH_SQ) begin
          if (quote_now == QUOTE_NONE) quote_now = QUOTE_SINGLE;
          else if (quote_now == QUOTE_SINGLE) quote_now = QUOTE_NONE;
          seq.push_back(c);
        end else if (quote_now == QUOTE_NONE && (c inside {CH_LT, CH_GT, CH_BAR, CH_AMP})) begin
          held_op = c;
        end else begin
          seq.push_back(c);
        end
      end
      // line end flushes any held operator and clears the line state
      if (eol) begin
        if (held_op != CH_NUL) begin
          seq.push_back(CH_SP);
          seq.push_back(held_op);
          seq.push_back(CH_SP);
        end
        quote_now = QUOTE_NONE;
        held_op = CH_NUL;
      end
      foreach (seq[i])
        step_beats.push_back('{seq[i], i == seq.size() - 1, eol && (i == seq.size() - 1), 1'b0});
    end
  endfunction

  // predict one accepted character and queue its beats
  task automatic expect_char(input logic [ByteW-1:0] c, input logic eol);
    space_step(c, eol);
    foreach (step_beats[i]) spaced_q.push_back(step_beats[i]);
  endtask

  // present one input beat after a random gap and wait for it to be taken
  task automatic send_char(input logic [ByteW-1:0] c, input logic eol);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid    <= 1'b1;
    in_chan.in_byte  <= c;
    in_chan.line_end <= eol;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // random character, weighted towards operators and quotes
  function automatic logic [ByteW-1:0] pick_char(input int op_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < op_pct) begin
      case ($urandom_range(0, 3))
        0:       return CH_LT;
        1:       return CH_GT;
        2:       return CH_BAR;
        default: return CH_AMP;
      endcase
    end else if (roll < op_pct + 12) begin
      return $urandom_range(0, 1) ? CH_DQ : CH_SQ;
    end else if (roll < op_pct + 20) begin
      return CH_SP;
    end
    return ByteW'($urandom_range(0, 255));
  endfunction

  // result side: random stalls, every accepted beat checked against the oldest expectation
  initial begin
    int           stall;
    spaced_beat_t want;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
      if (spaced_q.size() == 0) begin
        $error("unexpected result beat: out_byte %02h", out_chan.out_byte);
        mismatches++;
      end else begin
        want = spaced_q.pop_front();
        if (out_chan.out_byte !== want.data) begin
          $error("out_byte: expected %02h, got %02h", want.data, out_chan.out_byte);
          mismatches++;
        end
        if (out_chan.run_last !== want.run_last) begin
          $error("run_last: expected %0b, got %0b", want.run_last, out_chan.run_last);
          mismatches++;
        end
        if (out_chan.line_done !== want.line_done) begin
          $error("line_done: expected %0b, got %0b", want.line_done, out_chan.line_done);
          mismatches++;
        end
        if (out_chan.line_error !== want.line_error) begin
          $error("line_error: expected %0b, got %0b", want.line_error, out_chan.line_error);
          mismatches++;
        end
      end
    end
  end

  // stimulus
  initial begin
    int               n_sent;
    int               line_len;
    int               op_pct;
    logic             clean;
    logic             paused;
    logic [ByteW-1:0] c;
    logic [ByteW-1:0] prev;
    rst_n            <= 1'b0;
    in_chan.valid    <= 1'b0;
    in_chan.in_byte  <= '0;
    in_chan.line_end <= 1'b0;
    steady     = 1'b0;
    mismatches = 0;
    quote_now     = QUOTE_NONE;
    held_op       = CH_NUL;
    dropping_line = 1'b0;
    plan = '{
      '{"a",    1'b0, 1,         "a",    1'b0, 1'b0},  // plain byte after reset
      '{8'hFF,  1'b0, 1,         8'hFF,  1'b0, 1'b0},  // top byte value
      '{CH_NUL, 1'b0, 1,         CH_NUL, 1'b0, 1'b0},  // zero byte is literal
      '{CH_LT,  1'b0, 0,         CH_NUL, 1'b0, 1'b0},  // held
      '{CH_LT,  1'b0, FromModel, CH_NUL, 1'b0, 1'b0},  // << pair
      '{CH_LT,  1'b0, 0,         CH_NUL, 1'b0, 1'b0},
      '{"x",    1'b0, FromModel, CH_NUL, 1'b0, 1'b0},  // flush then literal
      '{CH_GT,  1'b0, 0,         CH_NUL, 1'b0, 1'b0},
      '{CH_GT,  1'b0, FromModel, CH_NUL, 1'b0, 1'b0},  // >> pair
      '{CH_GT,  1'b0, 0,         CH_NUL, 1'b0, 1'b0},  // third of >>> held afresh
      '{CH_BAR, 1'b0, FromModel, CH_NUL, 1'b0, 1'b0},
      '{CH_DQ,  1'b0, FromModel, CH_NUL, 1'b0, 1'b0},  // quote flushes held pipe
      '{CH_GT,  1'b0, FromModel, CH_NUL, 1'b0, 1'b0},  // literal inside double quotes
      '{CH_SQ,  1'b0, FromModel, CH_NUL, 1'b0, 1'b0},  // other quote kind is literal
      '{CH_DQ,  1'b0, FromModel, CH_NUL, 1'b0, 1'b0},
      '{CH_SQ,  1'b0, FromModel, CH_NUL, 1'b0, 1'b0},
      '{CH_AMP, 1'b0, FromModel, CH_NUL, 1'b0, 1'b0},
      '{CH_AMP, 1'b1, FromModel, CH_NUL, 1'b0, 1'b0},  // line ends inside single quotes
      '{CH_AMP, 1'b0, 0,         CH_NUL, 1'b0, 1'b0},
      '{CH_AMP, 1'b0, 0,         CH_NUL, 1'b0, 1'b0},  // && drops the line
      '{CH_LT,  1'b0, 0,         CH_NUL, 1'b0, 1'b0},
      '{"q",    1'b1, 1,         CH_NUL, 1'b1, 1'b1},  // error beat at line end
      '{CH_BAR, 1'b0, 0,         CH_NUL, 1'b0, 1'b0},
      '{CH_BAR, 1'b1, 1,         CH_NUL, 1'b1, 1'b1},  // || on the last byte
      '{CH_GT,  1'b1, FromModel, CH_NUL, 1'b0, 1'b0}   // operator at line end
    };
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (plan[r]) begin
      send_char(plan[r].ch, plan[r].eol);
      if (plan[r].n_typed == FromModel) begin
        expect_char(plan[r].ch, plan[r].eol);
      end else begin
        space_step(plan[r].ch, plan[r].eol);
        if (plan[r].n_typed == 1)
          spaced_q.push_back('{plan[r].typed_byte, 1'b1, plan[r].typed_done, plan[r].typed_err});
      end
    end

    // random lines, mostly free of && and ||
    n_sent = 0;
    paused = 1'b0;
    while (n_sent < RandomChars) begin
      steady   = ($urandom_range(0, 4) == 0);
      clean    = ($urandom_range(0, 3) != 0);
      op_pct   = $urandom_range(0, 60);
      line_len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      prev     = CH_NUL;
      for (int i = 0; i < line_len; i++) begin
        c = pick_char(op_pct);
        if (clean && (c == CH_AMP || c == CH_BAR) && c == prev) c = CH_GT;
        send_char(c, i == line_len - 1);
        expect_char(c, i == line_len - 1);
        prev = c;
        n_sent++;
      end
      // hold input off once until the block has drained
      if (!paused && n_sent > RandomChars / 2) begin
        in_chan.valid <= 1'b0;
        while (spaced_q.size() != 0) @(posedge clk);
        paused = 1'b1;
      end
    end
    in_chan.valid <= 1'b0;

    // drain, then wait for stray beats
    while (spaced_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
